@@ rtl/pts_pkg.sv @@
`default_nettype none
package pts_pkg;
   localparam int NumTasks   = 26;
   localparam int MaxWorkers = 8;
   localparam int TaskW      = 5;
   localparam int WorkW      = 3;
   localparam int TimeW      = 13;
   localparam logic [TimeW-1:0] TimeMax = 13'd8191;

   localparam logic [1:0] RegWorkers = 2'd0;
   localparam logic [1:0] RegBase    = 2'd1;
   localparam logic [1:0] RegTasks   = 2'd2;

   localparam logic [3:0] ResetWorkers = 4'd5;
   localparam logic [7:0] ResetBase    = 8'd61;
   localparam logic [4:0] ResetTasks   = 5'd26;

   // controller -> datapath
   typedef struct packed {
      logic init;     // clear run state
      logic scan;     // examine task at scan index
      logic advance;  // jump time to earliest finish, retire
      logic clear;    // clear matrix, started and busy flags at run end
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic scan_last;   // scan index at last task, no free worker, or last free worker taken
      logic any_busy;
   } stat_type;
endpackage
`default_nettype wire

@@ rtl/pts_ctrl.sv @@
`default_nettype none
module pts_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  start,
   input  wire                  req_mode,
   input  wire pts_pkg::stat_type stat,
   output pts_pkg::cmd_type     cmd,
   output logic                 busy,
   output logic                 sum_strobe
);
   typedef enum logic [2:0] {S_IDLE, S_SCAN, S_ADV, S_SUM} state_type;
   state_type state_ff;

   // commands decoded from state (init from start, busy and req_mode)
   always_comb begin
      cmd.init    = start && !busy && req_mode;
      cmd.scan    = (state_ff == S_SCAN);
      cmd.advance = (state_ff == S_ADV);
      cmd.clear   = (state_ff == S_SUM);
      busy        = (state_ff != S_IDLE);
      sum_strobe  = (state_ff == S_SUM);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         case (state_ff)
            S_IDLE: if (cmd.init) state_ff <= S_SCAN;
            S_SCAN: if (stat.scan_last) state_ff <= S_ADV;
            S_ADV:  state_ff <= stat.any_busy ? S_SCAN : S_SUM;
            S_SUM:  state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

@@ rtl/pts_data.sv @@
`default_nettype none
module pts_data (
   input  wire                    clock,
   input  wire                    reset,
   input  wire pts_pkg::cmd_type  cmd,
   input  wire                    edge_we,
   input  wire [4:0]              req_before_task,
   input  wire [4:0]              req_after_task,
   input  wire [3:0]              cfg_workers,
   input  wire [7:0]              cfg_base,
   input  wire [4:0]              cfg_tasks,
   input  wire                    sum_strobe,
   output pts_pkg::stat_type      stat,
   output logic                   rsp_valid,
   output logic                   rsp_record_kind,
   output logic [4:0]             rsp_task_index,
   output logic [12:0]            rsp_start_time,
   output logic [12:0]            rsp_end_time,
   output logic                   rsp_all_done,
   output logic                   rsp_last_result
);
   localparam int N = pts_pkg::NumTasks;
   localparam int W = pts_pkg::MaxWorkers;
   localparam int TW = pts_pkg::TimeW;

   logic [N-1:0] mat_ff [N];
   logic [N-1:0] started_ff, finished_ff, active_ff;
   logic [W-1:0] wbusy_ff, wmask_ff;
   logic [pts_pkg::TaskW-1:0] wtask_ff [W];
   logic [TW-1:0] wfin_ff [W];
   logic [TW-1:0] time_ff;
   logic [pts_pkg::TaskW-1:0] idx_ff, last_idx_ff;

   // free worker search
   logic [W-1:0] free;
   logic         have_free;
   logic [pts_pkg::WorkW-1:0] free_w;
   always_comb begin
      free = ~wbusy_ff & wmask_ff;
      have_free = |free;
      free_w = '0;
      for (int i = W-1; i >= 0; i--)
         if (free[i]) free_w = pts_pkg::WorkW'(i);
   end

   // readiness of scanned task
   logic ready;
   logic [TW+1:0] fin_sum;
   logic [TW-1:0] fin;
   always_comb begin
      ready = !started_ff[idx_ff] && ((mat_ff[idx_ff] & active_ff & ~finished_ff) == '0)
              && have_free && (idx_ff <= last_idx_ff) && active_ff[idx_ff];
      fin_sum = (TW+2)'(time_ff) + (TW+2)'(cfg_base) + (TW+2)'(idx_ff);
      fin = (fin_sum > (TW+2)'(pts_pkg::TimeMax)) ? pts_pkg::TimeMax : fin_sum[TW-1:0];
   end

   // earliest finish over busy workers
   logic [TW-1:0] earliest;
   always_comb begin
      earliest = pts_pkg::TimeMax;
      for (int i = 0; i < W; i++)
         if (wbusy_ff[i] && wfin_ff[i] < earliest) earliest = wfin_ff[i];
   end

   logic [4:0] tasks_eff;
   logic [3:0] work_eff;
   always_comb begin
      tasks_eff = (cfg_tasks > 5'(N)) ? 5'(N) : cfg_tasks;
      work_eff  = (cfg_workers == 4'd0) ? 4'd1 :
                  (cfg_workers > 4'(W)) ? 4'(W) : cfg_workers;
      stat.scan_last = (idx_ff >= last_idx_ff) || !have_free || ready && ($countones(free) == 1);
      stat.any_busy  = |wbusy_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < N; i++) mat_ff[i] <= '0;
         started_ff <= '0;
         wbusy_ff <= '0;
         time_ff <= '0;
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= 1'b0;
         if (edge_we && req_before_task < 5'(N) && req_after_task < 5'(N))
            mat_ff[req_after_task][req_before_task] <= 1'b1;
         if (cmd.init) begin
            started_ff <= '0; finished_ff <= '0; wbusy_ff <= '0; time_ff <= '0;
            idx_ff <= '0;
            last_idx_ff <= (tasks_eff == 5'd0) ? 5'd0 : tasks_eff - 5'd1;
            for (int i = 0; i < N; i++) active_ff[i] <= (5'(i) < tasks_eff);
            for (int i = 0; i < W; i++) wmask_ff[i] <= (4'(i) < work_eff);
         end
         if (cmd.scan) begin
            idx_ff <= stat.scan_last ? '0 : idx_ff + 5'd1;
            if (ready) begin
               started_ff[idx_ff] <= 1'b1;
               wbusy_ff[free_w] <= 1'b1;
               wtask_ff[free_w] <= idx_ff;
               wfin_ff[free_w] <= fin;
               rsp_valid <= 1'b1;
               rsp_record_kind <= 1'b0;
               rsp_task_index <= idx_ff;
               rsp_start_time <= time_ff;
               rsp_end_time <= fin;
               rsp_all_done <= 1'b0;
               rsp_last_result <= 1'b0;
            end
         end
         if (cmd.advance && |wbusy_ff) begin
            time_ff <= earliest;
            for (int i = 0; i < W; i++)
               if (wbusy_ff[i] && wfin_ff[i] == earliest) begin
                  wbusy_ff[i] <= 1'b0;
                  finished_ff[wtask_ff[i]] <= 1'b1;
               end
         end
         if (sum_strobe) begin
            rsp_valid <= 1'b1;
            rsp_record_kind <= 1'b1;
            rsp_task_index <= '0;
            rsp_start_time <= '0;
            rsp_end_time <= time_ff;
            rsp_all_done <= ((started_ff & active_ff) == active_ff);
            rsp_last_result <= 1'b1;
         end
         if (cmd.clear) begin
            for (int i = 0; i < N; i++) mat_ff[i] <= '0;
            started_ff <= '0;
            wbusy_ff <= '0;
         end
      end
   end
endmodule
`default_nettype wire

@@ rtl/precedence_task_scheduler.sv @@
// Precedence task scheduler. An edge command (mode 0) records a precedence edge without raising busy. A run
// command (mode 1) holds busy while the controller walks the task list one
// task per cycle per round (a round ends early once every worker is taken, and
// visits task index 0 even with no tasks), then a jump of time to the earliest
// finish after each round, and a summary state at the end; there are at most
// task_count + 1 rounds. Each start record and the
// final summary appear for exactly one cycle on rsp_valid; the summary beat
// comes in the cycle after busy falls, so the next command may be taken while
// it is on the outputs. The receiver cannot stall and must take every beat.
// Configure only while not busy.
`default_nettype none
module precedence_task_scheduler (
   input  wire        clock,
   input  wire        reset,
   input  wire        start,
   output logic       busy,
   input  wire        req_mode,
   input  wire [4:0]  req_before_task,
   input  wire [4:0]  req_after_task,
   output logic       rsp_valid,
   output logic       rsp_record_kind,
   output logic [4:0] rsp_task_index,
   output logic [12:0] rsp_start_time,
   output logic [12:0] rsp_end_time,
   output logic       rsp_all_done,
   output logic       rsp_last_result,
   input  wire        csr_psel,
   input  wire        csr_penable,
   input  wire        csr_pwrite,
   input  wire [3:0]  csr_paddr,
   input  wire [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic       csr_pready
);
   logic [3:0] workers_ff;
   logic [7:0] base_ff;
   logic [4:0] tasks_ff;
   pts_pkg::cmd_type  cmd;
   pts_pkg::stat_type stat;
   logic sum_strobe;

   assign csr_pready = 1'b1;

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         workers_ff <= pts_pkg::ResetWorkers;
         base_ff    <= pts_pkg::ResetBase;
         tasks_ff   <= pts_pkg::ResetTasks;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         case (csr_paddr[3:2])
            pts_pkg::RegWorkers: workers_ff <= csr_pwdata[3:0];
            pts_pkg::RegBase:    base_ff    <= csr_pwdata[7:0];
            pts_pkg::RegTasks:   tasks_ff   <= csr_pwdata[4:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         pts_pkg::RegWorkers: csr_prdata = {28'd0, workers_ff};
         pts_pkg::RegBase:    csr_prdata = {24'd0, base_ff};
         pts_pkg::RegTasks:   csr_prdata = {27'd0, tasks_ff};
         default:             csr_prdata = '0;
      endcase
   end

   pts_ctrl u_ctrl (
      .clock, .reset, .start, .req_mode, .stat, .cmd, .busy, .sum_strobe
   );

   pts_data u_data (
      .clock, .reset, .cmd,
      .edge_we(start && !busy && !req_mode),
      .req_before_task, .req_after_task,
      .cfg_workers(workers_ff), .cfg_base(base_ff), .cfg_tasks(tasks_ff),
      .sum_strobe, .stat,
      .rsp_valid, .rsp_record_kind, .rsp_task_index, .rsp_start_time,
      .rsp_end_time, .rsp_all_done, .rsp_last_result
   );
endmodule
`default_nettype wire

@@ rtl/pts_checker.sv @@
`default_nettype none
module pts_checker (
   input wire clock,
   input wire reset,
   input wire start,
   input wire busy,
   input wire req_mode,
   input wire rsp_valid,
   input wire rsp_record_kind,
   input wire rsp_last_result
);
   // an edge command never makes the block busy
   a_edge: assert property (@(posedge clock) disable iff (reset)
      start && !busy && !req_mode |=> !busy) else $error("edge set busy");
   // a run command starts a busy period
   a_run: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_mode |=> busy) else $error("run not busy");
   // the summary beat comes after the run has ended
   a_sum: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_record_kind |-> !busy) else $error("busy at summary");
   // last only on a summary
   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_last_result == rsp_record_kind) else $error("bad last");
   // no beats while idle
   a_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy)) else $error("beat while idle");
endmodule

bind precedence_task_scheduler pts_checker u_pts_checker (
   .clock, .reset, .start, .busy, .req_mode, .rsp_valid, .rsp_record_kind,
   .rsp_last_result
);
`default_nettype wire

@@ test/precedence_task_scheduler_checker.sv @@
`timescale 1ns / 100ps
`default_nettype none
module precedence_task_scheduler_checker (
   input  wire        clock,
   input  wire        reset,
   input  wire        start,
   input  wire        busy,
   input  wire        req_mode,
   input  wire [4:0]  req_before_task,
   input  wire [4:0]  req_after_task,
   input  wire        rsp_valid,
   input  wire        rsp_record_kind,
   input  wire [4:0]  rsp_task_index,
   input  wire [12:0] rsp_start_time,
   input  wire [12:0] rsp_end_time,
   input  wire        rsp_all_done,
   input  wire        rsp_last_result,
   input  wire        csr_psel,
   input  wire        csr_penable,
   input  wire        csr_pwrite,
   input  wire [3:0]  csr_paddr,
   input  wire [31:0] csr_pwdata,
   input  wire        csr_pready,
   output int         mismatches,
   output int         records_waiting,
   output int         records_seen
);
   localparam logic MODE_EDGE    = 1'b0;
   localparam logic KIND_START   = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   typedef struct packed {
      logic        kind;
      logic [4:0]  task_idx;
      logic [12:0] t_start;
      logic [12:0] t_finish;
      logic        done;
      logic        last;
   } record_type;

   record_type  schedule_q[$];
   logic [pts_pkg::NumTasks-1:0] waits_on[pts_pkg::NumTasks];
   logic [3:0]  cfg_workers;
   logic [7:0]  cfg_base;
   logic [4:0]  cfg_tasks;

   assign records_waiting = schedule_q.size();

   task automatic report(input string what, input int got, input int want);
      $display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, want);
      mismatches++;
   endtask

   // list schedule of the loaded precedence graph; queues every record of the run
   task automatic schedule_run();
      int      tasks, nw, now, earliest, free_w, fin;
      int      w_task[pts_pkg::MaxWorkers];
      int      w_fin[pts_pkg::MaxWorkers];
      logic [pts_pkg::MaxWorkers-1:0] w_busy;
      logic [pts_pkg::NumTasks-1:0]   in_use, finished, started;
      bit      any;
      record_type r;
      tasks = (cfg_tasks > pts_pkg::NumTasks) ? pts_pkg::NumTasks : cfg_tasks;
      nw = (cfg_workers == 0) ? 1 :
           ((cfg_workers > pts_pkg::MaxWorkers) ? pts_pkg::MaxWorkers : cfg_workers);
      in_use = '0;
      for (int t = 0; t < tasks; t++) in_use[t] = 1'b1;
      finished = '0;
      started = '0;
      w_busy = '0;
      now = 0;
      while (1) begin
         // one round: fill idle workers in ascending task order
         for (int t = 0; t < tasks; t++) begin
            free_w = nw;
            for (int w = nw - 1; w >= 0; w--)
               if (!w_busy[w]) free_w = w;
            if (free_w == nw) break;
            if (!started[t] && (waits_on[t] & in_use & ~finished) == '0) begin
               fin = now + cfg_base + t;
               if (fin > pts_pkg::TimeMax) fin = pts_pkg::TimeMax;
               started[t] = 1'b1;
               w_busy[free_w] = 1'b1;
               w_task[free_w] = t;
               w_fin[free_w] = fin;
               r = '{KIND_START, t[4:0], now[12:0], fin[12:0], 1'b0, 1'b0};
               schedule_q.insert(schedule_q.size(), r);
            end
         end
         // jump to earliest finish and retire
         any = 0;
         earliest = 0;
         for (int w = 0; w < nw; w++)
            if (w_busy[w] && (!any || w_fin[w] < earliest)) begin
               earliest = w_fin[w];
               any = 1;
            end
         if (!any) break;
         now = earliest;
         for (int w = 0; w < nw; w++)
            if (w_busy[w] && w_fin[w] == earliest) begin
               finished[w_task[w]] = 1'b1;
               w_busy[w] = 1'b0;
            end
      end
      r = '{KIND_SUMMARY, 5'd0, 13'd0, now[12:0], (started & in_use) == in_use, 1'b1};
      schedule_q.insert(schedule_q.size(), r);
      for (int t = 0; t < pts_pkg::NumTasks; t++) waits_on[t] = '0;
   endtask

   always @(posedge clock) begin
      record_type want;
      if (reset) begin
         for (int t = 0; t < pts_pkg::NumTasks; t++) waits_on[t] = '0;
         cfg_workers = pts_pkg::ResetWorkers;
         cfg_base    = pts_pkg::ResetBase;
         cfg_tasks   = pts_pkg::ResetTasks;
         schedule_q.delete();
         mismatches   = 0;
         records_seen <= 0;
      end else begin
         // compare an outgoing beat with the oldest prediction
         if (rsp_valid) begin
            records_seen <= records_seen + 1;
            if (schedule_q.size() == 0) begin
               report("unexpected record, kind", rsp_record_kind, -1);
            end else begin
               want = schedule_q.pop_front();
               if (rsp_record_kind !== want.kind) report("record_kind", rsp_record_kind, want.kind);
               if (rsp_task_index !== want.task_idx)
                  report("task_index", rsp_task_index, want.task_idx);
               if (rsp_start_time !== want.t_start)
                  report("start_time", rsp_start_time, want.t_start);
               if (rsp_end_time !== want.t_finish)
                  report("end_time", rsp_end_time, want.t_finish);
               if (rsp_all_done !== want.done) report("all_done", rsp_all_done, want.done);
               if (rsp_last_result !== want.last)
                  report("last_result", rsp_last_result, want.last);
            end
         end
         // register writes
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[3:2])
               pts_pkg::RegWorkers: cfg_workers = csr_pwdata[3:0];
               pts_pkg::RegBase:    cfg_base    = csr_pwdata[7:0];
               pts_pkg::RegTasks:   cfg_tasks   = csr_pwdata[4:0];
               default: ;
            endcase
         end
         // accepted command beat
         if (start && !busy) begin
            if (req_mode == MODE_EDGE) begin
               if (req_before_task < pts_pkg::NumTasks && req_after_task < pts_pkg::NumTasks)
                  waits_on[req_after_task][req_before_task] = 1'b1;
            end else begin
               schedule_run();
            end
         end
      end
   end
endmodule
`default_nettype wire

@@ test/precedence_task_scheduler_test.sv @@
`timescale 1ns / 100ps
`default_nettype none
module precedence_task_scheduler_test;
   localparam logic MODE_EDGE = 1'b0;
   localparam logic MODE_RUN  = 1'b1;
   localparam int   STALL_LIMIT = 20000;

   logic        clock = 0;
   logic        reset = 1;
   logic        start = 0;
   logic        busy;
   logic        req_mode = 0;
   logic [4:0]  req_before_task = 0;
   logic [4:0]  req_after_task = 0;
   logic        rsp_valid, rsp_record_kind, rsp_all_done, rsp_last_result;
   logic [4:0]  rsp_task_index;
   logic [12:0] rsp_start_time, rsp_end_time;
   logic        csr_psel = 0, csr_penable = 0, csr_pwrite = 0;
   logic [3:0]  csr_paddr = 0;
   logic [31:0] csr_pwdata = 0;
   logic [31:0] csr_prdata;
   logic        csr_pready;
   int          mismatches, records_waiting, records_seen;
   int          items_sent = 0, runs_sent = 0, phases = 0;
   int          quiet_cycles = 0;
   bit          allow_gaps = 1;

   precedence_task_scheduler dut (.*);

   precedence_task_scheduler_checker checker_i (
      .clock, .reset, .start, .busy, .req_mode, .req_before_task, .req_after_task,
      .rsp_valid, .rsp_record_kind, .rsp_task_index, .rsp_start_time,
      .rsp_end_time, .rsp_all_done, .rsp_last_result,
      .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr, .csr_pwdata, .csr_pready,
      .mismatches, .records_waiting, .records_seen);

   initial begin
      forever #4 clock = ~clock;
   end

   // watchdog: cycles without any accepted beat
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid || csr_psel) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // one command beat, held until accepted; sometimes a gap afterward
   task automatic send_cmd(input logic mode, input logic [4:0] before_t,
                           input logic [4:0] after_t);
      start <= 1'b1;
      req_mode <= mode;
      req_before_task <= before_t;
      req_after_task <= after_t;
      // busy is stable mid-cycle; accepted at the next rising edge once low
      @(negedge clock);
      while (busy) @(negedge clock);
      @(posedge clock);
      items_sent++;
      if (mode == MODE_RUN) runs_sent++;
      if (allow_gaps && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         req_mode <= 1'($urandom);
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
   endtask

   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (busy || records_waiting != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] reg_idx, input logic [31:0] value);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= {reg_idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic configure(input int workers, input int base, input int tasks);
      drain();
      csr_write(pts_pkg::RegWorkers, workers);
      csr_write(pts_pkg::RegBase, base);
      csr_write(pts_pkg::RegTasks, tasks);
      phases++;
   endtask

   // mostly forward edges (acyclic), plus back edges, self edges and bad indices
   task automatic random_graph(input int n_edges, input int tasks);
      int b, a, hi;
      hi = (tasks < 2) ? 1 : tasks - 1;
      for (int i = 0; i < n_edges; i++) begin
         b = $urandom_range(0, hi);
         a = $urandom_range(0, hi);
         case ($urandom_range(0, 19))
            0: a = b;
            1: b = $urandom_range(0, 31);
            2: a = $urandom_range(0, 31);
            3, 4: ;
            default: if (b > a) begin int s = a; a = b; b = s; end
         endcase
         send_cmd(MODE_EDGE, b[4:0], a[4:0]);
      end
      send_cmd(MODE_RUN, 5'($urandom), 5'($urandom));
   endtask

   initial begin
      int w, bd, tc;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: defaults, out-of-range, self edge, cycle
      send_cmd(MODE_RUN, 5'd0, 5'd0);
      send_cmd(MODE_EDGE, 5'd31, 5'd3);
      send_cmd(MODE_EDGE, 5'd2, 5'd26);
      send_cmd(MODE_EDGE, 5'd0, 5'd25);
      send_cmd(MODE_EDGE, 5'd25, 5'd1);
      send_cmd(MODE_EDGE, 5'd7, 5'd7);
      send_cmd(MODE_RUN, 5'd31, 5'd31);
      configure(1, 255, 26);
      for (int t = 0; t < 25; t++) send_cmd(MODE_EDGE, 5'(t), 5'(t + 1));
      send_cmd(MODE_RUN, 5'd0, 5'd0);
      configure(0, 0, 0);
      send_cmd(MODE_EDGE, 5'd0, 5'd1);
      send_cmd(MODE_RUN, 5'd0, 5'd0);
      configure(15, 0, 31);
      send_cmd(MODE_EDGE, 5'd3, 5'd4);
      send_cmd(MODE_EDGE, 5'd4, 5'd3);
      send_cmd(MODE_EDGE, 5'd20, 5'd2);
      send_cmd(MODE_RUN, 5'd0, 5'd0);
      configure(8, 1, 1);
      send_cmd(MODE_EDGE, 5'd5, 5'd0);
      send_cmd(MODE_RUN, 5'd0, 5'd0);

      // random phases; the last ones run without gaps
      for (int p = 0; p < 14; p++) begin
         w = (p % 5 == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8);
         bd = (p % 4 == 0) ? 255 : $urandom_range(0, 255);
         tc = (p % 6 == 0) ? $urandom_range(0, 31) : $urandom_range(1, 26);
         if (p >= 11) allow_gaps = 0;
         configure(w, bd, tc);
         for (int r = 0; r < 4; r++) random_graph($urandom_range(0, 10), tc);
      end
      drain();

      $display("checked %0d command beats (%0d runs) over %0d register settings",
               items_sent, runs_sent, phases);
      $display("%0d schedule records compared", records_seen);
      if (mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end
endmodule
`default_nettype wire
